[sv/vsbc_pkg.sv]
// Shared types and constants for the variant site block compressor.
`default_nettype none
package vsbc_pkg;

  localparam int POS_W     = 31;
  localparam int BS_W      = 16;
  localparam int NB_W      = 33;
  localparam int CNT_W     = 32;
  localparam int FIRST_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = POS_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAP,
    ST_LEN,
    ST_DONE
  } vsbc_state_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dividend;
    logic [BS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quotient;
    logic [BS_W-1:0]  remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

[sv/vsbc_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module vsbc_div
  import vsbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [POS_W-1:0]     quo_r;
  logic [BS_W-1:0]      rem_r;
  logic [BS_W-1:0]      dsr_r;

  logic [BS_W:0]        trial;
  logic [BS_W:0]        diff;
  logic                 ge;
  logic [BS_W-1:0]      rem_step;
  logic                 last_step;

  // Partial remainder stays below the divisor, so the trial fits one extra bit.
  assign trial     = {rem_r, quo_r[POS_W-1]};
  assign diff      = trial - {1'b0, dsr_r};
  assign ge        = trial >= {1'b0, dsr_r};
  assign rem_step  = ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
  assign last_step = cnt_r == DIV_CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[POS_W-2:0], ge};
      rem_r <= rem_step;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

[sv/variant_site_block_compressor.sv]
// Top level: variant site to compressed block index mapper.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | req_type, site_position, site_is_last
//   out_    | output    | out_valid/out_stall | status, new_index, filler_first, filler_count
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// For block size above one, a site with a gap before it takes the beat, runs the
// gap through the shared serial divider, picks up the quotient and commits the result.
// A finish beat divides the region length, after the gap when there is one,
// unless the block size is one or an earlier site has failed.
// Block size one, a site with no gap, or a beat after failure skips the divider.
// in_stall is high from the accepted beat until its result is committed to the
// output register; a stalled result holds the block in its commit step.
// Synchronous active-low reset; a configuration write to a known register also restarts the stream.
`default_nettype none
module variant_site_block_compressor
  import vsbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_req_type,
  input  wire logic [POS_W-1:0]     in_site_position,
  input  wire logic                 in_site_is_last,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_status,
  output logic [POS_W-1:0]          out_new_index,
  output logic signed [FIRST_W-1:0] out_filler_first,
  output logic [POS_W-1:0]          out_filler_count,

  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [POS_W-1:0]     cfg_wdata
);

  // configuration
  logic [POS_W-1:0] region_start_r, region_start_nxt;
  logic [POS_W-1:0] region_end_r, region_end_nxt;
  logic [BS_W-1:0]  block_size_r, block_size_nxt;

  // stream state
  logic [NB_W-1:0]  nb_r, nb_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic [CNT_W-1:0] lni_r, lni_nxt;
  logic             seen_r, seen_nxt;
  logic             failed_r, failed_nxt;

  vsbc_state_t      state_r, state_nxt;

  // current beat
  logic             fin_r, last_r, dead_r, gap_r;
  logic [POS_W-1:0] target_r;
  logic [POS_W-1:0] q_gap_r;
  logic [BS_W-1:0]  rem_gap_r;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_status_r;
  logic [POS_W-1:0]          out_idx_r;
  logic signed [FIRST_W-1:0] out_first_r;
  logic [POS_W-1:0]          out_count_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  vsbc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  logic [BS_W-1:0]  bs_eff;
  logic             bs_one;
  logic             in_acc;
  logic [POS_W-1:0] target_in;
  logic             tgt_ge_nb;
  logic [POS_W-1:0] gap_in;
  logic [POS_W-1:0] len;
  logic             commit;

  assign bs_eff    = (block_size_r == '0) ? BS_W'(1) : block_size_r;
  assign bs_one    = block_size_r <= BS_W'(1);
  assign in_stall  = state_r != ST_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign target_in = in_req_type ? region_end_r : in_site_position;
  assign tgt_ge_nb = {2'b00, target_in} >= nb_r;
  assign gap_in    = target_in - nb_r[POS_W-1:0];
  assign len       = (region_end_r >= region_start_r) ? region_end_r - region_start_r : '0;
  assign commit    = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = gap_in;
    div_req.divisor  = bs_eff;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (failed_r || bs_one) begin
            state_nxt = ST_DONE;
          end else if (tgt_ge_nb) begin
            div_req.start = 1'b1;
            state_nxt     = ST_GAP;
          end else if (in_req_type) begin
            div_req.start    = 1'b1;
            div_req.dividend = len;
            state_nxt        = ST_LEN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_GAP: begin
        if (div_rsp.done) begin
          if (fin_r) begin
            div_req.start    = 1'b1;
            div_req.dividend = len;
            state_nxt        = ST_LEN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_LEN: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // block size one: identity coordinates
  logic [NB_W-1:0]  cursor;
  logic [CNT_W-1:0] limit;
  logic             b1_has;
  logic [CNT_W-1:0] b1_count;
  logic [NB_W-1:0]  tplus2;
  logic [NB_W-1:0]  b1_nb;
  logic [POS_W-1:0] b1_idx;

  assign cursor   = nb_r - NB_W'(1);
  assign limit    = {1'b0, target_r} + CNT_W'(fin_r);
  assign b1_has   = {1'b0, limit} > cursor;
  assign b1_count = limit - cursor[CNT_W-1:0];
  assign tplus2   = {2'b00, target_r} + NB_W'(2);
  assign b1_nb    = (tplus2 > nb_r) ? tplus2 : nb_r;
  assign b1_idx   = (target_r >= region_start_r) ? target_r - region_start_r : '0;

  // larger blocks
  logic [CNT_W-1:0] bn_count;
  logic [CNT_W-1:0] bn_first;
  logic [NB_W-1:0]  bn_nb_a;
  logic [CNT_W:0]   bc_sum;
  logic [CNT_W-1:0] bn_idx;
  logic [CNT_W:0]   idx_p1;
  logic [CNT_W-1:0] bn_bc_site;
  logic [NB_W:0]    nb_sum;
  logic [NB_W-1:0]  bn_nb_site;
  logic             bn_fail;
  logic [CNT_W:0]   ne_len;
  logic [CNT_W:0]   lni_p1;
  logic [CNT_W:0]   bn_ne;

  assign bn_count   = gap_r ? {1'b0, q_gap_r} + CNT_W'(1) : '0;
  assign bn_first   = nb_r[CNT_W-1:0] - CNT_W'(bs_eff[BS_W-1:1]);
  // boundary after the gap: target minus remainder plus one block
  assign bn_nb_a    = gap_r ? {2'b00, target_r} - NB_W'(rem_gap_r) + NB_W'(bs_eff) : nb_r;
  assign bc_sum     = {1'b0, bc_r} + {1'b0, bn_count};
  assign bn_idx     = bc_sum[CNT_W] ? '1 : bc_sum[CNT_W-1:0];
  assign idx_p1     = {1'b0, bn_idx} + (CNT_W+1)'(1);
  assign bn_bc_site = idx_p1[CNT_W] ? '1 : idx_p1[CNT_W-1:0];
  assign nb_sum     = {1'b0, bn_nb_a} + (NB_W+1)'(bs_eff);
  assign bn_nb_site = nb_sum[NB_W] ? '1 : nb_sum[NB_W-1:0];
  assign bn_fail    = (bn_nb_a > {2'b00, region_end_r}) && !last_r;
  assign ne_len     = (CNT_W+1)'(div_rsp.quotient);
  assign lni_p1     = {1'b0, lni_r} + (CNT_W+1)'(1);
  assign bn_ne      = (seen_r && (lni_p1 > ne_len)) ? lni_p1 : ne_len;

  logic             res_status;
  logic [CNT_W:0]   res_idx;
  logic [CNT_W-1:0] res_first;
  logic [CNT_W-1:0] res_count;

  always_comb begin
    res_status = 1'b0;
    res_idx    = '0;
    res_first  = '0;
    res_count  = '0;
    if (dead_r) begin
      res_status = 1'b1;
    end else if (bs_one) begin
      res_idx = (CNT_W+1)'(b1_idx);
      if (b1_has) begin
        res_count = b1_count;
        res_first = cursor[CNT_W-1:0];
      end
    end else begin
      res_status = !fin_r && bn_fail;
      res_idx    = fin_r ? bn_ne : {1'b0, bn_idx};
      res_count  = bn_count;
      res_first  = (bn_count != '0) ? bn_first : '0;
    end
  end

  // next stream state and configuration
  logic [POS_W-1:0] start_w;
  logic [BS_W-1:0]  bs_w;
  logic [BS_W-1:0]  bs_w_eff;

  always_comb begin
    region_start_nxt = region_start_r;
    region_end_nxt   = region_end_r;
    block_size_nxt   = block_size_r;
    nb_nxt           = nb_r;
    bc_nxt           = bc_r;
    lni_nxt          = lni_r;
    seen_nxt         = seen_r;
    failed_nxt       = failed_r;
    start_w          = region_start_r;
    bs_w             = block_size_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_REGION_START: start_w = cfg_wdata;
        CFG_REGION_END:   region_end_nxt = cfg_wdata;
        CFG_BLOCK_SIZE:   bs_w = cfg_wdata[BS_W-1:0];
        default:          ;
      endcase
    end
    bs_w_eff = (bs_w == '0) ? BS_W'(1) : bs_w;
    if (cfg_we) begin
      // restart the stream only on a known register
      if (cfg_index == CFG_REGION_START || cfg_index == CFG_REGION_END ||
          cfg_index == CFG_BLOCK_SIZE) begin
        region_start_nxt = start_w;
        block_size_nxt   = bs_w;
        nb_nxt           = {2'b00, start_w} + NB_W'(bs_w_eff);
        bc_nxt           = '0;
        lni_nxt          = '0;
        seen_nxt         = 1'b0;
        failed_nxt       = 1'b0;
      end
    end else if (commit && !dead_r) begin
      if (bs_one) begin
        nb_nxt = b1_nb;
        if (!fin_r) begin
          lni_nxt  = CNT_W'(b1_idx);
          seen_nxt = 1'b1;
        end
      end else if (!fin_r) begin
        lni_nxt  = bn_idx;
        seen_nxt = 1'b1;
        bc_nxt   = bn_bc_site;
        nb_nxt   = bn_nb_site;
        if (bn_fail) begin
          failed_nxt = 1'b1;
        end
      end else begin
        bc_nxt = bn_idx;
        nb_nxt = bn_nb_a;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      region_start_r <= '0;
      region_end_r   <= '0;
      block_size_r   <= BS_W'(1);
      nb_r           <= NB_W'(1);
      bc_r           <= '0;
      lni_r          <= '0;
      seen_r         <= 1'b0;
      failed_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      region_start_r <= region_start_nxt;
      region_end_r   <= region_end_nxt;
      block_size_r   <= block_size_nxt;
      nb_r           <= nb_nxt;
      bc_r           <= bc_nxt;
      lni_r          <= lni_nxt;
      seen_r         <= seen_nxt;
      failed_r       <= failed_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // beat and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fin_r    <= in_req_type;
      last_r   <= in_site_is_last;
      target_r <= target_in;
      dead_r   <= failed_r;
      gap_r    <= tgt_ge_nb;
    end
    if (state_r == ST_GAP && div_rsp.done) begin
      q_gap_r   <= div_rsp.quotient;
      rem_gap_r <= div_rsp.remainder;
    end
    if (commit) begin
      out_status_r <= res_status;
      out_idx_r    <= (res_idx > (CNT_W+1)'(POS_MAX)) ? POS_MAX : res_idx[POS_W-1:0];
      out_first_r  <= res_first;
      out_count_r  <= (res_count > CNT_W'(POS_MAX)) ? POS_MAX : res_count[POS_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_new_index    = out_idx_r;
  assign out_filler_first = out_first_r;
  assign out_filler_count = out_count_r;

`ifndef SYNTH
  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r && !cfg_we |=> failed_r)
    else $error("failure flag dropped without a configuration write");

  a_empty_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_filler_count == '0) |-> out_filler_first == '0)
    else $error("empty filler run carries a nonzero first coordinate");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_GAP || state_r == ST_LEN))
    else $error("divider finished while the sequencer was not waiting");

  a_hold_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid && out_stall |=> state_r == ST_DONE)
    else $error("result committed over a stalled beat");
`endif

endmodule
`default_nettype wire
